// ----- src/ruc_pkg.sv -----
`default_nettype none
package ruc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W = 32;
   localparam int THR_W = 17;
   localparam int AXES = 3;
   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int DEN_W = DATA_W;
   localparam int REM_W = DEN_W + 1;
   localparam int QUO_W = NUM_W + 1;
   localparam int DIV_LAT = NUM_W + 1;

   localparam logic signed [DATA_W:0] ONE_WIDE = (DATA_W + 1)'(1) <<< FRAC_BITS;
   localparam logic signed [QUO_W-1:0] LO_FREE = {1'b1, {(QUO_W - 1){1'b0}}};
   localparam logic signed [QUO_W-1:0] HI_FREE = {1'b0, {(QUO_W - 1){1'b1}}};
   localparam logic signed [QUO_W-1:0] SAT_MAX = QUO_W'({1'b0, {(DATA_W - 1){1'b1}}});
   localparam logic signed [QUO_W-1:0] SAT_MIN = -SAT_MAX - QUO_W'(1);
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef enum logic [1:0] {
      AXIS_BOUNDED,
      AXIS_FREE,
      AXIS_MISS
   } axis_mode_type;

   typedef struct packed {
      logic valid;
      axis_mode_type [AXES-1:0] mode;
   } side_type;

endpackage
`default_nettype wire

// ----- src/ruc_div.sv -----
`default_nettype none
module ruc_div (
   input  wire logic clock,
   input  wire logic enable,
   input  wire logic [ruc_pkg::NUM_W-1:0] in_num,
   input  wire logic [ruc_pkg::DEN_W-1:0] in_den,
   input  wire logic in_neg,
   output logic signed [ruc_pkg::QUO_W-1:0] out_quo
);

   logic [ruc_pkg::DEN_W-1:0] rem_ff [ruc_pkg::NUM_W];
   logic [ruc_pkg::DEN_W-1:0] rem_in [ruc_pkg::NUM_W];
   logic [ruc_pkg::NUM_W-1:0] work_ff [ruc_pkg::NUM_W];
   logic [ruc_pkg::NUM_W-1:0] work_in [ruc_pkg::NUM_W];
   logic [ruc_pkg::DEN_W-1:0] den_ff [ruc_pkg::NUM_W];
   logic [ruc_pkg::DEN_W-1:0] den_in [ruc_pkg::NUM_W];
   logic neg_ff [ruc_pkg::NUM_W];
   logic neg_in [ruc_pkg::NUM_W];
   logic signed [ruc_pkg::QUO_W-1:0] quo_ff;
   logic signed [ruc_pkg::QUO_W-1:0] quo_in;

   // one quotient bit per stage, restoring
   always_comb begin
      logic [ruc_pkg::DEN_W-1:0] src_rem;
      logic [ruc_pkg::NUM_W-1:0] src_work;
      logic [ruc_pkg::DEN_W-1:0] src_den;
      logic src_neg;
      logic [ruc_pkg::REM_W-1:0] part;
      logic [ruc_pkg::REM_W:0] diff;
      for (int s = 0; s < ruc_pkg::NUM_W; s++) begin
         if (s == 0) begin
            src_rem = '0;
            src_work = in_num;
            src_den = in_den;
            src_neg = in_neg;
         end else begin
            src_rem = rem_ff[s-1];
            src_work = work_ff[s-1];
            src_den = den_ff[s-1];
            src_neg = neg_ff[s-1];
         end
         part = {src_rem, src_work[ruc_pkg::NUM_W-1]};
         diff = {1'b0, part} - {2'b00, src_den};
         if (!diff[ruc_pkg::REM_W]) begin
            rem_in[s] = diff[ruc_pkg::DEN_W-1:0];
            work_in[s] = {src_work[ruc_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in[s] = part[ruc_pkg::DEN_W-1:0];
            work_in[s] = {src_work[ruc_pkg::NUM_W-2:0], 1'b0};
         end
         den_in[s] = src_den;
         neg_in[s] = src_neg;
      end
      if (neg_ff[ruc_pkg::NUM_W-1]) begin
         quo_in = -$signed({1'b0, work_ff[ruc_pkg::NUM_W-1]});
      end else begin
         quo_in = $signed({1'b0, work_ff[ruc_pkg::NUM_W-1]});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < ruc_pkg::NUM_W; s++) begin
            rem_ff[s] <= rem_in[s];
            work_ff[s] <= work_in[s];
            den_ff[s] <= den_in[s];
            neg_ff[s] <= neg_in[s];
         end
         quo_ff <= quo_in;
      end
   end

   assign out_quo = quo_ff;

endmodule
`default_nettype wire

// ----- src/ray_unit_cube_slab_intersect.sv -----
// path: input to prep registers, then the dividers, then order, reduce and response registers
// throughput: one ray per cycle unless results stall; six 48-stage pipelined dividers, one bit each
// a stall on the result side holds the whole pipeline in place
// reset: synchronous, clears all valid bits and sets the parallel threshold to 1
`default_nettype none
module ray_unit_cube_slab_intersect (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_en,
   input  wire logic [ruc_pkg::THR_W-1:0] csr_write_data,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic signed [ruc_pkg::DATA_W-1:0] req_origin_x,
   input  wire logic signed [ruc_pkg::DATA_W-1:0] req_origin_y,
   input  wire logic signed [ruc_pkg::DATA_W-1:0] req_origin_z,
   input  wire logic signed [ruc_pkg::DATA_W-1:0] req_direction_x,
   input  wire logic signed [ruc_pkg::DATA_W-1:0] req_direction_y,
   input  wire logic signed [ruc_pkg::DATA_W-1:0] req_direction_z,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic rsp_hit,
   output logic signed [ruc_pkg::DATA_W-1:0] rsp_t_near,
   output logic signed [ruc_pkg::DATA_W-1:0] rsp_t_far
);

   localparam int A = ruc_pkg::AXES;
   localparam int DW = ruc_pkg::DATA_W;
   localparam int QW = ruc_pkg::QUO_W;

   logic adv;
   logic [ruc_pkg::THR_W-1:0] thr_ff;

   logic signed [DW-1:0] org [A];
   logic signed [DW-1:0] dir [A];

   logic [ruc_pkg::NUM_W-1:0] num0_ff [A], num0_in [A];
   logic [ruc_pkg::NUM_W-1:0] num1_ff [A], num1_in [A];
   logic [ruc_pkg::DEN_W-1:0] den_ff [A], den_in [A];
   logic neg0_ff [A], neg0_in [A];
   logic neg1_ff [A], neg1_in [A];
   ruc_pkg::side_type prep_ff, prep_in;
   ruc_pkg::side_type side_ff [ruc_pkg::DIV_LAT];

   logic signed [QW-1:0] quo0 [A];
   logic signed [QW-1:0] quo1 [A];

   logic signed [QW-1:0] lo_ff [A], lo_in [A];
   logic signed [QW-1:0] hi_ff [A], hi_in [A];
   logic ord_valid_ff, ord_miss_ff, ord_miss_in;

   logic signed [QW-1:0] near_ff, near_in, far_ff, far_in;
   logic red_valid_ff, red_hit_ff, red_hit_in;

   logic rsp_valid_ff, rsp_hit_ff;
   logic signed [DW-1:0] rsp_near_ff, rsp_near_in, rsp_far_ff, rsp_far_in;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_direction_x;
   assign dir[1] = req_direction_y;
   assign dir[2] = req_direction_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ruc_pkg::THR_RESET;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   // operand prep: numerator magnitudes, divisor magnitude, signs, parallel test
   always_comb begin
      logic signed [DW:0] o_w, n0, n1, d_w, d_abs;
      logic [DW-1:0] m0, m1;
      logic par, in_slab;
      prep_in.valid = req_valid;
      for (int a = 0; a < A; a++) begin
         o_w = {org[a][DW-1], org[a]};
         d_w = {dir[a][DW-1], dir[a]};
         n0 = -ruc_pkg::ONE_WIDE - o_w;
         n1 = ruc_pkg::ONE_WIDE - o_w;
         m0 = n0[DW] ? DW'(-n0) : n0[DW-1:0];
         m1 = n1[DW] ? DW'(-n1) : n1[DW-1:0];
         d_abs = d_w[DW] ? -d_w : d_w;
         num0_in[a] = {m0, {ruc_pkg::FRAC_BITS{1'b0}}};
         num1_in[a] = {m1, {ruc_pkg::FRAC_BITS{1'b0}}};
         den_in[a] = d_abs[DW-1:0];
         neg0_in[a] = n0[DW] ^ dir[a][DW-1];
         neg1_in[a] = n1[DW] ^ dir[a][DW-1];
         par = (d_abs[DW-1:0] == '0) ||
               (d_abs[DW-1:0] < {{(DW - ruc_pkg::THR_W){1'b0}}, thr_ff});
         in_slab = (o_w >= -ruc_pkg::ONE_WIDE) && (o_w <= ruc_pkg::ONE_WIDE);
         if (!par) begin
            prep_in.mode[a] = ruc_pkg::AXIS_BOUNDED;
         end else if (in_slab) begin
            prep_in.mode[a] = ruc_pkg::AXIS_FREE;
         end else begin
            prep_in.mode[a] = ruc_pkg::AXIS_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < A; a++) begin
            num0_ff[a] <= num0_in[a];
            num1_ff[a] <= num1_in[a];
            den_ff[a] <= den_in[a];
            neg0_ff[a] <= neg0_in[a];
            neg1_ff[a] <= neg1_in[a];
         end
      end
   end

   for (genvar g = 0; g < A; g++) begin : g_axis
      ruc_div u_div0 (
         .clock   (clock),
         .enable  (adv),
         .in_num  (num0_ff[g]),
         .in_den  (den_ff[g]),
         .in_neg  (neg0_ff[g]),
         .out_quo (quo0[g])
      );
      ruc_div u_div1 (
         .clock   (clock),
         .enable  (adv),
         .in_num  (num1_ff[g]),
         .in_den  (den_ff[g]),
         .in_neg  (neg1_ff[g]),
         .out_quo (quo1[g])
      );
   end

   // side data rides along with the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff.mode <= prep_in.mode;
         side_ff[0].mode <= prep_ff.mode;
         for (int s = 1; s < ruc_pkg::DIV_LAT; s++) begin
            side_ff[s].mode <= side_ff[s-1].mode;
         end
      end
      if (reset) begin
         prep_ff.valid <= 1'b0;
         for (int s = 0; s < ruc_pkg::DIV_LAT; s++) begin
            side_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         prep_ff.valid <= prep_in.valid;
         side_ff[0].valid <= prep_ff.valid;
         for (int s = 1; s < ruc_pkg::DIV_LAT; s++) begin
            side_ff[s].valid <= side_ff[s-1].valid;
         end
      end
   end

   // order each pair of a bounded axis; free and missed axes get open bounds, and a missed axis flags a miss
   always_comb begin
      ord_miss_in = 1'b0;
      for (int a = 0; a < A; a++) begin
         unique case (side_ff[ruc_pkg::DIV_LAT-1].mode[a])
            ruc_pkg::AXIS_BOUNDED: begin
               lo_in[a] = (quo0[a] > quo1[a]) ? quo1[a] : quo0[a];
               hi_in[a] = (quo0[a] > quo1[a]) ? quo0[a] : quo1[a];
            end
            ruc_pkg::AXIS_MISS: begin
               lo_in[a] = ruc_pkg::LO_FREE;
               hi_in[a] = ruc_pkg::HI_FREE;
               ord_miss_in = 1'b1;
            end
            default: begin
               lo_in[a] = ruc_pkg::LO_FREE;
               hi_in[a] = ruc_pkg::HI_FREE;
            end
         endcase
      end
   end

   // largest entry, smallest exit; a hit needs no missed axis and entry <= exit
   always_comb begin
      near_in = lo_ff[0];
      far_in = hi_ff[0];
      for (int a = 1; a < A; a++) begin
         if (lo_ff[a] > near_in) begin
            near_in = lo_ff[a];
         end
         if (hi_ff[a] < far_in) begin
            far_in = hi_ff[a];
         end
      end
      red_hit_in = !ord_miss_ff && (near_in <= far_in);
   end

   always_comb begin
      if (!red_hit_ff) begin
         rsp_near_in = '0;
         rsp_far_in = '0;
      end else begin
         if (near_ff > ruc_pkg::SAT_MAX) begin
            rsp_near_in = ruc_pkg::SAT_MAX[DW-1:0];
         end else if (near_ff < ruc_pkg::SAT_MIN) begin
            rsp_near_in = ruc_pkg::SAT_MIN[DW-1:0];
         end else begin
            rsp_near_in = near_ff[DW-1:0];
         end
         if (far_ff > ruc_pkg::SAT_MAX) begin
            rsp_far_in = ruc_pkg::SAT_MAX[DW-1:0];
         end else if (far_ff < ruc_pkg::SAT_MIN) begin
            rsp_far_in = ruc_pkg::SAT_MIN[DW-1:0];
         end else begin
            rsp_far_in = far_ff[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_valid_ff <= 1'b0;
         red_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         ord_valid_ff <= side_ff[ruc_pkg::DIV_LAT-1].valid;
         red_valid_ff <= ord_valid_ff;
         rsp_valid_ff <= red_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < A; a++) begin
            lo_ff[a] <= lo_in[a];
            hi_ff[a] <= hi_in[a];
         end
         ord_miss_ff <= ord_miss_in;
         near_ff <= near_in;
         far_ff <= far_in;
         red_hit_ff <= red_hit_in;
         rsp_hit_ff <= red_hit_ff;
         rsp_near_ff <= rsp_near_in;
         rsp_far_ff <= rsp_far_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_t_near = rsp_near_ff;
   assign rsp_t_far = rsp_far_ff;

endmodule
`default_nettype wire
